FILE: hw/rtl/rge_pkg.sv
// Shared types and constants for the reversible gate executor with undo.
// Holds operation, gate and status codes, the undo record layout and the
// command and status structs between controller and datapath. No dependencies.
package rge_pkg;

   localparam int NUM_BITS_DEF   = 256;
   localparam int HIST_DEPTH_DEF = 4096;

   localparam int KindW  = 2;
   localparam int GateW  = 2;
   localparam int IdxW   = 8;
   localparam int StatW  = 2;
   localparam int DepthW = 13;
   localparam int CfgW   = 9;

   localparam logic [CfgW-1:0] ACTIVE_BITS_RST = 9'd256;

   localparam logic [KindW-1:0] KIND_GATE  = 2'd0;
   localparam logic [KindW-1:0] KIND_READ  = 2'd1;
   localparam logic [KindW-1:0] KIND_WRITE = 2'd2;
   localparam logic [KindW-1:0] KIND_UNDO  = 2'd3;

   localparam logic [GateW-1:0] GATE_CCNOT = 2'd0;
   localparam logic [GateW-1:0] GATE_CNOT  = 2'd1;
   localparam logic [GateW-1:0] GATE_NOT   = 2'd2;
   localparam logic [GateW-1:0] GATE_SWAP  = 2'd3;

   localparam logic [StatW-1:0] STAT_DONE  = 2'd0;
   localparam logic [StatW-1:0] STAT_RANGE = 2'd1;
   localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;
   localparam logic [StatW-1:0] STAT_FULL  = 2'd3;

   // One entry of the undo stack.
   typedef struct packed {
      logic [GateW-1:0] gate;
      logic [IdxW-1:0]  idx_a;
      logic [IdxW-1:0]  idx_b;
      logic [IdxW-1:0]  idx_c;
   } rec_type;

   localparam int RecW = $bits(rec_type);

   typedef struct packed {
      logic             clr_wr;
      logic             latch;
      logic             pop;
      logic             load_rec;
      logic             push;
      logic             set_status;
      logic [StatW-1:0] status;
      logic             rd_a;
      logic             rd_b;
      logic             rd_c;
      logic             wr1;
      logic             wr2;
      logic             resp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic             clr_last;
      logic [KindW-1:0] kind;
      logic [GateW-1:0] gate;
      logic             range_ok;
      logic             hist_empty;
      logic             hist_full;
      logic             rsp_free;
   } dp_flag_type;

endpackage

FILE: hw/rtl/rge_req_if.sv
// Request channel of the reversible gate executor: valid/ready plus item fields.
// Depends on rge_pkg for field widths.
interface rge_req_if;
   import rge_pkg::*;

   logic            valid;
   logic            ready;
   logic [KindW-1:0] kind;
   logic [GateW-1:0] gate;
   logic [IdxW-1:0]  index_a;
   logic [IdxW-1:0]  index_b;
   logic [IdxW-1:0]  index_c;
   logic             write_value;

   modport source (output valid, kind, gate, index_a, index_b, index_c, write_value,
                   input ready);
   modport sink   (input valid, kind, gate, index_a, index_b, index_c, write_value,
                   output ready);
endinterface

FILE: hw/rtl/rge_rsp_if.sv
// Response channel of the reversible gate executor: valid/ready plus result fields.
// Depends on rge_pkg for field widths.
interface rge_rsp_if;
   import rge_pkg::*;

   logic              valid;
   logic              ready;
   logic [StatW-1:0]  status;
   logic              read_value;
   logic [DepthW-1:0] history_depth;

   modport source (output valid, status, read_value, history_depth, input ready);
   modport sink   (input valid, status, read_value, history_depth, output ready);
endinterface

FILE: hw/rtl/reversible_gate_executor_with_undo_unit.sv
// Top level of the reversible gate executor with undo stack.
// Depends on rge_pkg, rge_req_if, rge_rsp_if, rge_ctrl and rge_dpath.
//
//   Channel  Direction  Handshake            Carries
//   req      in         req_bus.valid/ready  kind, gate, index_a..c, write_value
//   rsp      out        rsp_bus.valid/ready  status, read_value, history_depth
//   csr      in         csr_write_enable     active_bits (9 bits)
//
// One item at a time: three bit reads through the single read port, then writes.
// An item that passes decode and check goes through the reads and write state WR1
// (a SWAP also WR2), then loads the response register; an undo first pops its record.
// The next item can be accepted in the cycle after that load. After reset the bit
// store is cleared one entry per cycle, and no item is accepted until the clear ends.
// A response waiting in its register stalls the next item only at its last state.
module reversible_gate_executor_with_undo_unit #(
   parameter int NUM_BITS      = rge_pkg::NUM_BITS_DEF,
   parameter int HISTORY_DEPTH = rge_pkg::HIST_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   rge_req_if.sink                  req_bus,
   rge_rsp_if.source                rsp_bus,
   input  logic                     csr_write_enable,
   input  logic [rge_pkg::CfgW-1:0] csr_write_data
);
   import rge_pkg::*;

   ctl_cmd_type cmd;
   dp_flag_type flags;

   rge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   rge_dpath #(.NUM_BITS(NUM_BITS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_kind          (req_bus.kind),
      .req_gate          (req_bus.gate),
      .req_index_a       (req_bus.index_a),
      .req_index_b       (req_bus.index_b),
      .req_index_c       (req_bus.index_c),
      .req_write_value   (req_bus.write_value),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_read_value    (rsp_bus.read_value),
      .rsp_history_depth (rsp_bus.history_depth),
      .cmd               (cmd),
      .flags             (flags)
   );
endmodule

FILE: hw/rtl/rge_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rge_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hw/rtl/rge_ctrl.sv
// Sequencing state machine of the reversible gate executor.
// Depends on rge_pkg for the command and flag structs.
module rge_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rge_pkg::dp_flag_type flags,
   output rge_pkg::ctl_cmd_type cmd
);
   import rge_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_POP, ST_CHECK,
      ST_RD_A, ST_RD_B, ST_RD_C, ST_WR1, ST_WR2, ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      gate_like;

   // Undo replays the popped record as a gate.
   assign gate_like = (flags.kind == KIND_GATE) || (flags.kind == KIND_UNDO);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (flags.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (flags.kind == KIND_UNDO) begin
               if (flags.hist_empty) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STAT_EMPTY;
                  state_in       = ST_RESP;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = ST_POP;
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_POP: begin
            cmd.load_rec = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (!flags.range_ok) begin
               cmd.set_status = 1'b1;
               cmd.status     = STAT_RANGE;
               state_in       = ST_RESP;
            end else if ((flags.kind == KIND_GATE) && flags.hist_full) begin
               cmd.set_status = 1'b1;
               cmd.status     = STAT_FULL;
               state_in       = ST_RESP;
            end else begin
               cmd.push = (flags.kind == KIND_GATE);
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            cmd.rd_a = 1'b1;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.rd_b = 1'b1;
            state_in = ST_RD_C;
         end
         ST_RD_C: begin
            cmd.rd_c = 1'b1;
            state_in = ST_WR1;
         end
         ST_WR1: begin
            cmd.wr1 = 1'b1;
            if (gate_like && (flags.gate == GATE_SWAP)) state_in = ST_WR2;
            else state_in = ST_RESP;
         end
         ST_WR2: begin
            cmd.wr2  = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (flags.rsp_free) begin
               cmd.resp_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   logic ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;
endmodule

FILE: hw/rtl/rge_dpath.sv
// Datapath of the reversible gate executor: bit store RAM, undo stack RAM,
// history counter, range checks and the response register.
// Depends on rge_pkg and rge_ram.
module rge_dpath #(
   parameter int NUM_BITS      = rge_pkg::NUM_BITS_DEF,
   parameter int HISTORY_DEPTH = rge_pkg::HIST_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [rge_pkg::CfgW-1:0]    csr_write_data,
   input  logic [rge_pkg::KindW-1:0]   req_kind,
   input  logic [rge_pkg::GateW-1:0]   req_gate,
   input  logic [rge_pkg::IdxW-1:0]    req_index_a,
   input  logic [rge_pkg::IdxW-1:0]    req_index_b,
   input  logic [rge_pkg::IdxW-1:0]    req_index_c,
   input  logic                        req_write_value,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [rge_pkg::StatW-1:0]   rsp_status,
   output logic                        rsp_read_value,
   output logic [rge_pkg::DepthW-1:0]  rsp_history_depth,
   input  rge_pkg::ctl_cmd_type        cmd,
   output rge_pkg::dp_flag_type        flags
);
   import rge_pkg::*;

   localparam int BitAw = $clog2(NUM_BITS);
   localparam int StkAw = $clog2(HISTORY_DEPTH);
   localparam int CntW  = $clog2(HISTORY_DEPTH + 1);

   logic [CfgW-1:0]  active_bits_ff;
   logic [BitAw-1:0] clr_cnt_ff;
   logic [CntW-1:0]  count_ff;
   logic [KindW-1:0] kind_ff;
   logic [GateW-1:0] gate_ff;
   logic [IdxW-1:0]  a_ff, b_ff, c_ff;
   logic             wval_ff;
   logic             va_ff, vb_ff;
   logic [StatW-1:0] status_ff;

   logic             rsp_valid_ff;
   logic [StatW-1:0] rsp_status_ff;
   logic             rsp_rd_ff;
   logic [CntW-1:0]  rsp_depth_ff;

   // Undo stack.
   rec_type          push_rec, pop_rec;
   logic [RecW-1:0]  stk_rdata;

   assign push_rec = '{gate: gate_ff, idx_a: a_ff, idx_b: b_ff, idx_c: c_ff};
   assign pop_rec  = rec_type'(stk_rdata);

   rge_ram #(.WIDTH(RecW), .DEPTH(HISTORY_DEPTH)) u_stack (
      .clock (clock),
      .we    (cmd.push),
      .waddr (StkAw'(count_ff)),
      .wdata (push_rec),
      .raddr (StkAw'(count_ff - CntW'(1))),
      .rdata (stk_rdata)
   );

   // Bit store.
   logic             bit_we, bit_wdata, bit_rdata;
   logic [BitAw-1:0] bit_waddr, bit_raddr;
   logic             gate_like;

   assign gate_like = (kind_ff == KIND_GATE) || (kind_ff == KIND_UNDO);

   always_comb begin
      if (cmd.rd_b) bit_raddr = BitAw'(b_ff);
      else if (cmd.rd_c) bit_raddr = BitAw'(c_ff);
      else bit_raddr = BitAw'(a_ff);
   end

   // In the first write cycle bit_rdata holds the bit at index c.
   always_comb begin
      bit_we    = 1'b0;
      bit_waddr = BitAw'(a_ff);
      bit_wdata = 1'b0;
      if (cmd.clr_wr) begin
         bit_we    = 1'b1;
         bit_waddr = clr_cnt_ff;
      end else if (cmd.wr2) begin
         bit_we    = 1'b1;
         bit_waddr = BitAw'(b_ff);
         bit_wdata = va_ff;
      end else if (cmd.wr1) begin
         if (gate_like) begin
            case (gate_ff)
               GATE_CCNOT: begin
                  bit_we    = va_ff & vb_ff;
                  bit_waddr = BitAw'(c_ff);
                  bit_wdata = ~bit_rdata;
               end
               GATE_CNOT: begin
                  bit_we    = va_ff;
                  bit_waddr = BitAw'(b_ff);
                  bit_wdata = ~vb_ff;
               end
               GATE_NOT: begin
                  bit_we    = 1'b1;
                  bit_wdata = ~va_ff;
               end
               default: begin
                  bit_we    = 1'b1;
                  bit_wdata = vb_ff;
               end
            endcase
         end else if (kind_ff == KIND_WRITE) begin
            bit_we    = 1'b1;
            bit_wdata = wval_ff;
         end
      end
   end

   rge_ram #(.WIDTH(1), .DEPTH(NUM_BITS)) u_bits (
      .clock (clock),
      .we    (bit_we),
      .waddr (bit_waddr),
      .wdata (bit_wdata),
      .raddr (bit_raddr),
      .rdata (bit_rdata)
   );

   // An index is valid below both the active bit count and the store size.
   logic a_ok, b_ok, c_ok, range_ok;

   assign a_ok = ({1'b0, a_ff} < active_bits_ff) && (32'(a_ff) < 32'(NUM_BITS));
   assign b_ok = ({1'b0, b_ff} < active_bits_ff) && (32'(b_ff) < 32'(NUM_BITS));
   assign c_ok = ({1'b0, c_ff} < active_bits_ff) && (32'(c_ff) < 32'(NUM_BITS));

   always_comb begin
      if (gate_like) begin
         range_ok = a_ok && ((gate_ff == GATE_NOT) || b_ok) &&
                    ((gate_ff != GATE_CCNOT) || c_ok);
      end else begin
         range_ok = a_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_bits_ff <= ACTIVE_BITS_RST;
         clr_cnt_ff     <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) active_bits_ff <= csr_write_data;
         if (cmd.clr_wr) clr_cnt_ff <= clr_cnt_ff + BitAw'(1);
         if (cmd.pop) count_ff <= count_ff - CntW'(1);
         else if (cmd.push) count_ff <= count_ff + CntW'(1);
         if (cmd.resp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff   <= req_kind;
         gate_ff   <= req_gate;
         a_ff      <= req_index_a;
         b_ff      <= req_index_b;
         c_ff      <= req_index_c;
         wval_ff   <= req_write_value;
         status_ff <= STAT_DONE;
      end else begin
         if (cmd.load_rec) begin
            gate_ff <= pop_rec.gate;
            a_ff    <= pop_rec.idx_a;
            b_ff    <= pop_rec.idx_b;
            c_ff    <= pop_rec.idx_c;
         end
         if (cmd.set_status) status_ff <= cmd.status;
      end
      if (cmd.rd_b) va_ff <= bit_rdata;
      if (cmd.rd_c) vb_ff <= bit_rdata;
      if (cmd.resp_load) begin
         rsp_status_ff <= status_ff;
         rsp_rd_ff     <= (kind_ff == KIND_READ) && (status_ff == STAT_DONE) && va_ff;
         rsp_depth_ff  <= count_ff;
      end
   end

   assign flags.clr_last   = (clr_cnt_ff == BitAw'(NUM_BITS - 1));
   assign flags.kind       = kind_ff;
   assign flags.gate       = gate_ff;
   assign flags.range_ok   = range_ok;
   assign flags.hist_empty = (count_ff == '0);
   assign flags.hist_full  = (count_ff == CntW'(HISTORY_DEPTH));
   assign flags.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_value    = rsp_rd_ff;
   assign rsp_history_depth = DepthW'(rsp_depth_ff);
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the reversible gate executor with undo: random and directed gate, read,
// write and undo transactions, each result checked against a scoreboard predictor.
// Depends on rge_pkg, rge_req_if, rge_rsp_if and reversible_gate_executor_with_undo_unit.
module tb_top;
   import rge_pkg::*;

   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 230;
   localparam int MAX_PRINTS   = 100;

   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [GateW-1:0] gate;
      logic [IdxW-1:0]  index_a;
      logic [IdxW-1:0]  index_b;
      logic [IdxW-1:0]  index_c;
      logic             write_value;
   } gate_item_type;

   typedef struct packed {
      logic [StatW-1:0]  status;
      logic              read_value;
      logic [DepthW-1:0] history_depth;
   } gate_result_type;

   class gate_scoreboard_type;
      logic [NUM_BITS_DEF-1:0] bit_store;
      rec_type                 undo_stack[$];
      logic [CfgW-1:0]         active_bits;
      gate_result_type         pending_results[$];
      int                      error_count;
      int                      results_seen;

      function new();
         bit_store     = '0;
         active_bits   = ACTIVE_BITS_RST;
         error_count   = 0;
         results_seen  = 0;
      endfunction

      function void set_active_bits(logic [CfgW-1:0] value);
         active_bits = value;
      endfunction

      function int unsigned bit_limit();
         return (active_bits < NUM_BITS_DEF) ? active_bits : NUM_BITS_DEF;
      endfunction

      function int unsigned history_size();
         return undo_stack.size();
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction

      // Only the indices that the gate actually uses are checked.
      function bit indices_ok(rec_type r);
         int unsigned lim;
         lim = bit_limit();
         if (r.idx_a >= lim) return 1'b0;
         if (r.gate != GATE_NOT && r.idx_b >= lim) return 1'b0;
         if (r.gate == GATE_CCNOT && r.idx_c >= lim) return 1'b0;
         return 1'b1;
      endfunction

      function void apply_gate(rec_type r);
         logic held;
         case (r.gate)
            GATE_CCNOT: begin
               if (bit_store[r.idx_a] && bit_store[r.idx_b])
                  bit_store[r.idx_c] = ~bit_store[r.idx_c];
            end
            GATE_CNOT: begin
               if (bit_store[r.idx_a]) bit_store[r.idx_b] = ~bit_store[r.idx_b];
            end
            GATE_NOT: begin
               bit_store[r.idx_a] = ~bit_store[r.idx_a];
            end
            default: begin
               held               = bit_store[r.idx_a];
               bit_store[r.idx_a] = bit_store[r.idx_b];
               bit_store[r.idx_b] = held;
            end
         endcase
      endfunction

      function gate_result_type predict_gate_item(gate_item_type it);
         gate_result_type res;
         rec_type         rec;
         res         = '0;
         rec.gate    = it.gate;
         rec.idx_a   = it.index_a;
         rec.idx_b   = it.index_b;
         rec.idx_c   = it.index_c;
         case (it.kind)
            KIND_GATE: begin
               if (!indices_ok(rec)) begin
                  res.status = STAT_RANGE;
               end else if (undo_stack.size() >= HIST_DEPTH_DEF) begin
                  res.status = STAT_FULL;
               end else begin
                  apply_gate(rec);
                  undo_stack.push_back(rec);
               end
            end
            KIND_READ: begin
               if (it.index_a >= bit_limit()) res.status = STAT_RANGE;
               else res.read_value = bit_store[it.index_a];
            end
            KIND_WRITE: begin
               if (it.index_a >= bit_limit()) res.status = STAT_RANGE;
               else bit_store[it.index_a] = it.write_value;
            end
            default: begin
               if (undo_stack.size() == 0) begin
                  res.status = STAT_EMPTY;
               end else begin
                  // The record is popped even when its indices no longer fit.
                  rec = undo_stack.pop_back();
                  if (indices_ok(rec)) apply_gate(rec);
                  else res.status = STAT_RANGE;
               end
            end
         endcase
         res.history_depth = DepthW'(undo_stack.size());
         return res;
      endfunction

      function void note_accepted_item(gate_item_type it);
         pending_results.push_back(predict_gate_item(it));
      endfunction

      task report_mismatch(string msg);
         error_count++;
         if (error_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_result(gate_result_type got);
         gate_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing pending: %p",
                                      results_seen, got));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.read_value !== want.read_value ||
             got.history_depth !== want.history_depth)
            report_mismatch($sformatf("result %0d: got status %0d read %0d depth %0d, want %0d %0d %0d",
                                      results_seen, got.status, got.read_value,
                                      got.history_depth, want.status, want.read_value,
                                      want.history_depth));
      endtask

      task check_leftovers();
         if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      endtask
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_write_enable;
   logic [CfgW-1:0] csr_write_data;
   logic            rsp_blocked;

   int send_idle_pct    = 0;
   int sink_stall_pct   = 0;
   int holdoff_request  = 0;

   gate_scoreboard_type sb = new();

   rge_req_if req_bus ();
   rge_rsp_if rsp_bus ();

   reversible_gate_executor_with_undo_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

   // Keeps the result side stalled for the holdoff that a phase requests.
   initial begin : holdoff_timer
      int n;
      rsp_blocked = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request > 0) begin
            n               = holdoff_request;
            holdoff_request = 0;
            rsp_blocked <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_blocked <= 1'b0;
         end
      end
   end

   initial begin : result_sink
      gate_result_type got;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status        = rsp_bus.status;
            got.read_value    = rsp_bus.read_value;
            got.history_depth = rsp_bus.history_depth;
            sb.check_result(got);
         end
         rsp_bus.ready <= !rsp_blocked && ($urandom_range(99) >= sink_stall_pct);
      end
   end

   function automatic gate_item_type make_item(logic [KindW-1:0] kind,
                                               logic [GateW-1:0] gate,
                                               int a, int b, int c, bit wv);
      gate_item_type it;
      it.kind        = kind;
      it.gate        = gate;
      it.index_a     = IdxW'(a);
      it.index_b     = IdxW'(b);
      it.index_c     = IdxW'(c);
      it.write_value = wv;
      return it;
   endfunction

   // Mostly indices that fit the active range, now and then any index at all.
   function automatic logic [IdxW-1:0] pick_index();
      int unsigned lim;
      lim = sb.bit_limit();
      if (lim == 0 || $urandom_range(9) == 0) return IdxW'($urandom_range(255));
      return IdxW'($urandom_range(lim - 1));
   endfunction

   function automatic gate_item_type random_item();
      gate_item_type it;
      int unsigned   pick;
      pick = $urandom_range(99);
      if (pick < 45) it.kind = KIND_GATE;
      else if (pick < 65) it.kind = KIND_READ;
      else if (pick < 82) it.kind = KIND_WRITE;
      else it.kind = KIND_UNDO;
      it.gate        = GateW'($urandom_range(3));
      it.index_a     = pick_index();
      it.index_b     = pick_index();
      it.index_c     = pick_index();
      it.write_value = 1'($urandom_range(1));
      return it;
   endfunction

   task automatic send_item(gate_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= it.kind;
      req_bus.gate        <= it.gate;
      req_bus.index_a     <= it.index_a;
      req_bus.index_b     <= it.index_b;
      req_bus.index_c     <= it.index_c;
      req_bus.write_value <= it.write_value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_accepted_item(it);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_active_bits(logic [CfgW-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_active_bits(value);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random_phase(logic [CfgW-1:0] active, int idle_pct, int stall_pct,
                                   int holdoff);
      drain_results();
      write_active_bits(active);
      send_idle_pct   = idle_pct;
      sink_stall_pct  = stall_pct;
      holdoff_request = holdoff;
      repeat (PHASE_ITEMS) send_item(random_item());
   endtask

   initial begin : stimulus
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_READ;
      req_bus.gate        = GATE_CCNOT;
      req_bus.index_a     = '0;
      req_bus.index_b     = '0;
      req_bus.index_c     = '0;
      req_bus.write_value = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_active_bits(9'd256);
      send_item(make_item(KIND_UNDO, GATE_NOT, 0, 0, 0, 0));
      send_item(make_item(KIND_READ, GATE_NOT, 255, 0, 0, 0));
      send_item(make_item(KIND_WRITE, GATE_NOT, 255, 0, 0, 1));
      send_item(make_item(KIND_WRITE, GATE_NOT, 0, 0, 0, 1));
      send_item(make_item(KIND_READ, GATE_NOT, 255, 0, 0, 0));
      send_item(make_item(KIND_GATE, GATE_CCNOT, 0, 255, 128, 0));
      send_item(make_item(KIND_GATE, GATE_CNOT, 128, 1, 0, 0));
      send_item(make_item(KIND_GATE, GATE_NOT, 255, 0, 0, 0));
      send_item(make_item(KIND_GATE, GATE_SWAP, 0, 254, 0, 0));
      // Coinciding indices: these gates do not undo themselves.
      send_item(make_item(KIND_WRITE, GATE_NOT, 3, 0, 0, 1));
      send_item(make_item(KIND_GATE, GATE_CNOT, 3, 3, 0, 0));
      send_item(make_item(KIND_GATE, GATE_CCNOT, 1, 1, 1, 0));
      send_item(make_item(KIND_UNDO, GATE_NOT, 0, 0, 0, 0));
      send_item(make_item(KIND_UNDO, GATE_NOT, 0, 0, 0, 0));
      send_item(make_item(KIND_READ, GATE_NOT, 3, 0, 0, 0));
      send_item(make_item(KIND_WRITE, GATE_NOT, 200, 0, 0, 1));
      send_item(make_item(KIND_GATE, GATE_SWAP, 200, 201, 0, 0));

      // Shrinking the range leaves the last record out of range for its undo.
      drain_results();
      write_active_bits(9'd1);
      send_item(make_item(KIND_UNDO, GATE_NOT, 0, 0, 0, 0));
      send_item(make_item(KIND_READ, GATE_NOT, 1, 0, 0, 0));
      send_item(make_item(KIND_WRITE, GATE_NOT, 255, 0, 0, 1));
      send_item(make_item(KIND_GATE, GATE_CNOT, 0, 1, 0, 0));
      send_item(make_item(KIND_GATE, GATE_CCNOT, 0, 0, 1, 0));
      send_item(make_item(KIND_GATE, GATE_NOT, 0, 255, 255, 0));
      send_item(make_item(KIND_GATE, GATE_SWAP, 0, 0, 255, 0));

      drain_results();
      write_active_bits(9'd0);
      send_item(make_item(KIND_READ, GATE_NOT, 0, 0, 0, 0));
      send_item(make_item(KIND_UNDO, GATE_NOT, 0, 0, 0, 0));

      drain_results();
      write_active_bits(9'd511);
      send_item(make_item(KIND_READ, GATE_NOT, 255, 0, 0, 0));

      run_random_phase(9'd256, 0, 0, 300);
      run_random_phase(9'($urandom_range(2, 16)), 47, 0, 0);
      run_random_phase(9'($urandom_range(17, 255)), 0, 47, 0);
      run_random_phase(9'd511, 12, 12, 0);

      drain_results();
      sb.check_leftovers();
      if (sb.error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
